@@ rtl/slpa_pkg.sv @@
package slpa_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int CORDIC_STEPS     = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
    localparam int SQRT_STEPS       = 32;
    localparam int GEOM_LAT         = 7;
    localparam int ATAN_LAT         = 2 + CORDIC_STEPS;

    localparam logic [31:0] ANG_ZERO    = 32'h0000_0000;
    localparam logic [31:0] ANG_QUARTER = 32'h4000_0000;
    localparam logic [31:0] ANG_HALF    = 32'h8000_0000;
    localparam logic [31:0] ANG_3QUART  = 32'hC000_0000;

    localparam logic [15:0] POLAR_MAX  = 16'd18000;
    localparam logic [15:0] FULL_TURN  = 16'd36000;
    localparam logic [47:0] HUND_SCALE = 48'd36000;
    localparam logic [47:0] HUND_ROUND = 48'h0000_8000_0000;

    localparam logic [31:0] ATAN_TAB [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_DIST = 2'd1,
        ST_NO_FRAME  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [30:0] xp;
        logic [30:0]        aa;
        logic [30:0]        ab;
        logic               sa;
        logic               sb;
        logic [4:0]         t;
        t_status            st;
    } t_side;

    typedef struct packed {
        logic [61:0] vp;
        logic [61:0] va;
        t_side       side;
    } t_geom;

    function automatic logic [6:0] f_bitlen(input logic [63:0] v);
        logic [6:0] bl;
        bl = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) bl = 7'(i + 1);
        end
        return bl;
    endfunction

endpackage

@@ rtl/slpa_geom.sv @@
module slpa_geom import slpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [19:0] i_sx,
    input  logic signed [19:0] i_sy,
    input  logic signed [19:0] i_sz,
    input  logic signed [19:0] i_qx,
    input  logic signed [19:0] i_qy,
    input  logic signed [19:0] i_qz,
    output logic               o_valid,
    output t_geom              o_data
);

    logic [GEOM_LAT-1:0] r_vld;

    // stage 1
    logic signed [19:0] r1_px, r1_py, r1_pz;
    logic signed [20:0] r1_dx, r1_dy, r1_dz;
    // stage 2
    logic signed [40:0] r2_pydz, r2_pzdy, r2_pzdx, r2_pxdz, r2_pxdy, r2_pydx;
    logic signed [40:0] r2_pxdx, r2_pydy, r2_pzdz, r2_pxpx, r2_pypy, r2_pzpz;
    logic signed [20:0] r2_dz;
    logic signed [19:0] r2_pz;
    t_status            r2_st;
    // stage 3
    logic signed [41:0] r3_c0, r3_c1, r3_c2, r3_q, r3_rho2, r3_n;
    logic signed [42:0] r3_dot;
    logic signed [20:0] r3_dz;
    logic signed [19:0] r3_pz;
    t_status            r3_st;
    // stage 4
    logic [42:0]        r4_m0, r4_m1, r4_m2, r4_m3;
    logic [3:0]         r4_sp;
    logic               r4_dneg, r4_pzneg;
    logic signed [63:0] r4_rdz, r4_pzq;
    logic signed [41:0] r4_a;
    logic [4:0]         r4_t;
    logic [41:0]        r4_n;
    t_status            r4_st;
    // stage 5
    logic [29:0]        r5_m0, r5_m1, r5_m2, r5_m3;
    logic               r5_dneg;
    logic signed [63:0] r5_b;
    logic signed [41:0] r5_a;
    logic [4:0]         r5_t;
    logic [61:0]        r5_va;
    t_status            r5_st;
    // stage 6
    logic [59:0]        r6_q0, r6_q1, r6_q2;
    logic [29:0]        r6_m3;
    logic               r6_dneg, r6_sa, r6_sb;
    logic [41:0]        r6_aa;
    logic [63:0]        r6_ab;
    logic [4:0]         r6_sh, r6_t;
    logic [61:0]        r6_va;
    t_status            r6_st;
    // stage 7
    t_geom              r7_data;

    logic [42:0] w_m0, w_m1, w_m2, w_m3;
    logic [6:0]  w_blp, w_bln, w_tn, w_bla;
    logic [41:0] w_aa;
    logic [63:0] w_ab;
    t_status     w_st;

    always_comb begin
        if (r1_dx == 0 && r1_dy == 0 && r1_dz == 0) begin
            w_st = ST_ZERO_DIST;
        end else if (r1_pz == 0 || (r1_px == 0 && r1_py == 0)) begin
            w_st = ST_NO_FRAME;
        end else begin
            w_st = ST_OK;
        end
    end

    always_comb begin
        w_m0  = (r3_c0 < 0) ? 43'(-r3_c0) : 43'(r3_c0);
        w_m1  = (r3_c1 < 0) ? 43'(-r3_c1) : 43'(r3_c1);
        w_m2  = (r3_c2 < 0) ? 43'(-r3_c2) : 43'(r3_c2);
        w_m3  = (r3_dot < 0) ? 43'(-r3_dot) : 43'(r3_dot);
        w_blp = f_bitlen(64'(w_m0 | w_m1 | w_m2 | w_m3));
        w_bln = f_bitlen(64'(r3_n));
        w_tn  = (w_bln == 0) ? 7'd30 : 7'((7'd62 - w_bln) >> 1);
        if (w_tn > 7'd30) w_tn = 7'd30;
        w_aa  = (r5_a < 0) ? 42'(-r5_a) : 42'(r5_a);
        w_ab  = (r5_b < 0) ? 64'(-r5_b) : 64'(r5_b);
        w_bla = f_bitlen(64'(w_aa) | w_ab);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[GEOM_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_px <= i_sx;
            r1_py <= i_sy;
            r1_pz <= i_sz;
            r1_dx <= {i_qx[19], i_qx} - {i_sx[19], i_sx};
            r1_dy <= {i_qy[19], i_qy} - {i_sy[19], i_sy};
            r1_dz <= {i_qz[19], i_qz} - {i_sz[19], i_sz};

            r2_pydz <= r1_py * r1_dz;
            r2_pzdy <= r1_pz * r1_dy;
            r2_pzdx <= r1_pz * r1_dx;
            r2_pxdz <= r1_px * r1_dz;
            r2_pxdy <= r1_px * r1_dy;
            r2_pydx <= r1_py * r1_dx;
            r2_pxdx <= r1_px * r1_dx;
            r2_pydy <= r1_py * r1_dy;
            r2_pzdz <= r1_pz * r1_dz;
            r2_pxpx <= r1_px * r1_px;
            r2_pypy <= r1_py * r1_py;
            r2_pzpz <= r1_pz * r1_pz;
            r2_dz   <= r1_dz;
            r2_pz   <= r1_pz;
            r2_st   <= w_st;

            r3_c0   <= r2_pydz - r2_pzdy;
            r3_c1   <= r2_pzdx - r2_pxdz;
            r3_c2   <= r2_pxdy - r2_pydx;
            r3_dot  <= -(r2_pxdx + r2_pydy + r2_pzdz);
            r3_q    <= r2_pxdx + r2_pydy;
            r3_rho2 <= r2_pxpx + r2_pypy;
            r3_n    <= r2_pxpx + r2_pypy + r2_pzpz;
            r3_dz   <= r2_dz;
            r3_pz   <= r2_pz;
            r3_st   <= r2_st;

            r4_m0    <= w_m0;
            r4_m1    <= w_m1;
            r4_m2    <= w_m2;
            r4_m3    <= w_m3;
            r4_sp    <= (w_blp > 7'd30) ? 4'(w_blp - 7'd30) : 4'd0;
            r4_dneg  <= r3_dot < 0;
            r4_pzneg <= r3_pz < 0;
            r4_rdz   <= r3_rho2 * r3_dz;
            r4_pzq   <= r3_pz * r3_q;
            r4_a     <= r3_c2;
            r4_t     <= 5'(w_tn);
            r4_n     <= 42'(r3_n);
            r4_st    <= r3_st;

            r5_m0   <= 30'(r4_m0 >> r4_sp);
            r5_m1   <= 30'(r4_m1 >> r4_sp);
            r5_m2   <= 30'(r4_m2 >> r4_sp);
            r5_m3   <= 30'(r4_m3 >> r4_sp);
            r5_dneg <= r4_dneg;
            r5_b    <= r4_pzneg ? (r4_pzq - r4_rdz) : (r4_rdz - r4_pzq);
            r5_a    <= r4_a;
            r5_t    <= r4_t;
            r5_va   <= 62'(64'(r4_n) << {r4_t, 1'b0});
            r5_st   <= r4_st;

            r6_q0   <= r5_m0 * r5_m0;
            r6_q1   <= r5_m1 * r5_m1;
            r6_q2   <= r5_m2 * r5_m2;
            r6_m3   <= r5_m3;
            r6_dneg <= r5_dneg;
            r6_sa   <= r5_a < 0;
            r6_sb   <= r5_b < 0;
            r6_aa   <= w_aa;
            r6_ab   <= w_ab;
            r6_sh   <= (w_bla > 7'd31) ? 5'(w_bla - 7'd31) : 5'd0;
            r6_t    <= r5_t;
            r6_va   <= r5_va;
            r6_st   <= r5_st;

            r7_data.vp      <= 62'(r6_q0) + 62'(r6_q1) + 62'(r6_q2);
            r7_data.va      <= r6_va;
            r7_data.side.xp <= r6_dneg ? -$signed({1'b0, r6_m3}) : $signed({1'b0, r6_m3});
            r7_data.side.aa <= 31'(r6_aa >> r6_sh);
            r7_data.side.ab <= 31'(r6_ab >> r6_sh);
            r7_data.side.sa <= r6_sa;
            r7_data.side.sb <= r6_sb;
            r7_data.side.t  <= r6_t;
            r7_data.side.st <= r6_st;
        end
    end

    assign o_valid = r_vld[GEOM_LAT-1];
    assign o_data  = r7_data;

endmodule

@@ rtl/slpa_isqrt.sv @@
module slpa_isqrt import slpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [61:0] i_v,
    output logic        o_valid,
    output logic [30:0] o_s
);

    logic [SQRT_STEPS-1:0] r_vld;
    logic [61:0]           r_v [SQRT_STEPS];
    logic [62:0]           r_r [SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_STEPS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [61:0] w_vin;
        logic [62:0] w_rin, w_bit, w_sum;

        if (k == 0) begin : g_first
            assign w_vin = i_v;
            assign w_rin = '0;
        end else begin : g_next
            assign w_vin = r_v[k-1];
            assign w_rin = r_r[k-1];
        end

        assign w_bit = 63'(1) << (62 - 2 * k);
        assign w_sum = w_rin + w_bit;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, w_vin} >= w_sum) begin
                    r_v[k] <= w_vin - 62'(w_sum);
                    r_r[k] <= (w_rin >> 1) + w_bit;
                end else begin
                    r_v[k] <= w_vin;
                    r_r[k] <= w_rin >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_s     = 31'(r_r[SQRT_STEPS-1]);

endmodule

@@ rtl/slpa_atan2.sv @@
module slpa_atan2 import slpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_x,
    output logic               o_valid,
    output logic [31:0]        o_ang
);

    logic [CORDIC_STEPS+1:0] r_vld;

    // stage A: magnitudes, axis cases, shift
    logic [62:0] r_ay, r_ax;
    logic [5:0]  r_sh;
    logic        r_negx, r_negy, r_axis;
    logic [31:0] r_axang;
    // stage B: rotated start vector
    logic signed [33:0] r_bcx, r_bcy;
    logic [31:0]        r_bang, r_baxang;
    logic               r_baxis;

    logic signed [33:0] r_cx [CORDIC_STEPS];
    logic signed [33:0] r_cy [CORDIC_STEPS];
    logic [31:0]        r_ang [CORDIC_STEPS];
    logic [31:0]        r_xa [CORDIC_STEPS];
    logic               r_xf [CORDIC_STEPS];

    logic [62:0] w_ay, w_ax;
    logic [6:0]  w_bl;
    logic [29:0] w_say, w_sax;

    always_comb begin
        w_ay  = (i_y < 0) ? 63'(-i_y) : 63'(i_y);
        w_ax  = (i_x < 0) ? 63'(-i_x) : 63'(i_x);
        w_bl  = f_bitlen(64'(w_ay | w_ax));
        w_say = 30'(r_ay >> r_sh);
        w_sax = 30'(r_ax >> r_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[CORDIC_STEPS:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ay   <= w_ay;
            r_ax   <= w_ax;
            r_sh   <= (w_bl > 7'd30) ? 6'(w_bl - 7'd30) : 6'd0;
            r_negx <= i_x < 0;
            r_negy <= i_y < 0;
            r_axis <= (w_ay == 0) || (w_ax == 0);
            if (w_ay == 0 && w_ax == 0) begin
                r_axang <= ANG_ZERO;
            end else if (w_ay == 0) begin
                r_axang <= (i_x > 0) ? ANG_ZERO : ANG_HALF;
            end else begin
                r_axang <= (i_y > 0) ? ANG_QUARTER : ANG_3QUART;
            end

            r_bcx    <= $signed({4'b0, w_sax});
            r_bcy    <= (r_negx ^ r_negy) ? -$signed({4'b0, w_say}) : $signed({4'b0, w_say});
            r_bang   <= r_negx ? ANG_HALF : ANG_ZERO;
            r_baxis  <= r_axis;
            r_baxang <= r_axang;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [33:0] w_cx, w_cy;
        logic [31:0]        w_ang, w_xa;
        logic               w_xf;

        if (i == 0) begin : g_first
            assign w_cx  = r_bcx;
            assign w_cy  = r_bcy;
            assign w_ang = r_bang;
            assign w_xa  = r_baxang;
            assign w_xf  = r_baxis;
        end else begin : g_next
            assign w_cx  = r_cx[i-1];
            assign w_cy  = r_cy[i-1];
            assign w_ang = r_ang[i-1];
            assign w_xa  = r_xa[i-1];
            assign w_xf  = r_xf[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cy > 0) begin
                    r_cx[i]  <= w_cx + (w_cy >>> i);
                    r_cy[i]  <= w_cy - (w_cx >>> i);
                    r_ang[i] <= w_ang + ATAN_TAB[i];
                end else begin
                    r_cx[i]  <= w_cx - (w_cy >>> i);
                    r_cy[i]  <= w_cy + (w_cx >>> i);
                    r_ang[i] <= w_ang - ATAN_TAB[i];
                end
                r_xa[i] <= w_xa;
                r_xf[i] <= w_xf;
            end
        end
    end

    assign o_valid = r_vld[CORDIC_STEPS+1];
    assign o_ang   = r_xf[CORDIC_STEPS-1] ? r_xa[CORDIC_STEPS-1] : r_ang[CORDIC_STEPS-1];

endmodule

@@ rtl/sensor_local_polar_azimuth_angles_top.sv @@
// Sensor-local polar and azimuth angles of an event point.
// Input channel: i_valid / o_stall with sensor and point coordinates, one
// transaction per event. Output channel: o_valid / i_stall with the polar
// angle, the azimuth and a status code, one transaction per input.
// A transaction moves when valid is high and stall is low.
// Throughput: one event per cycle while the receiver does not stall. An
// event passes through the 7-stage geometry front end, the 32-stage
// square root pipeline, the product stage, the CORDIC arctangent
// pipeline (2 + CORDIC_STEPS stages) and two output stages.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_stall is raised; nothing is lost or repeated. Reset clears every
// valid bit; no result appears until a new event has passed through.
// Degenerate geometry returns zero angles with a nonzero status.
module sensor_local_polar_azimuth_angles_top import slpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [19:0] i_sensor_x,
    input  logic signed [19:0] i_sensor_y,
    input  logic signed [19:0] i_sensor_z,
    input  logic signed [19:0] i_point_x,
    input  logic signed [19:0] i_point_y,
    input  logic signed [19:0] i_point_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [14:0]        o_polar_angle,
    output logic [15:0]        o_azimuth_angle,
    output logic [1:0]         o_status
);

    logic        w_en;
    logic        w_gvld, w_sqp_vld, w_sqa_vld, w_atp_vld, w_ata_vld;
    t_geom       w_geom;
    logic [30:0] w_sqp, w_sqa;
    logic [31:0] w_angp, w_anga;
    logic [61:0] w_yy, w_xx;
    logic [47:0] w_hp, w_ha;

    t_side              r_side [SQRT_STEPS];
    logic signed [63:0] r_py, r_px, r_ay, r_ax;
    logic               r_mvld;
    t_status            r_mst;
    t_status            r_ast [ATAN_LAT];
    logic               r_cvld;
    logic [15:0]        r_hp, r_ha;
    logic               r_cneg;
    t_status            r_cst;
    logic               r_ovld;
    logic [14:0]        r_opol;
    logic [15:0]        r_oazi;
    t_status            r_ost;

    assign w_en    = !(r_ovld && i_stall);
    assign o_stall = !w_en;

    slpa_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_sx    (i_sensor_x),
        .i_sy    (i_sensor_y),
        .i_sz    (i_sensor_z),
        .i_qx    (i_point_x),
        .i_qy    (i_point_y),
        .i_qz    (i_point_z),
        .o_valid (w_gvld),
        .o_data  (w_geom)
    );

    slpa_isqrt u_sqrt_pol (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_gvld),
        .i_v     (w_geom.vp),
        .o_valid (w_sqp_vld),
        .o_s     (w_sqp)
    );

    slpa_isqrt u_sqrt_azi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_gvld),
        .i_v     (w_geom.va),
        .o_valid (w_sqa_vld),
        .o_s     (w_sqa)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_geom.side;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign w_yy = 62'(r_side[SQRT_STEPS-1].aa) * 62'(w_sqa);
    assign w_xx = 62'(r_side[SQRT_STEPS-1].ab) << r_side[SQRT_STEPS-1].t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else if (w_en) begin
            r_mvld <= w_sqp_vld && w_sqa_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_py  <= $signed({33'b0, w_sqp});
            r_px  <= 64'(r_side[SQRT_STEPS-1].xp);
            r_ay  <= r_side[SQRT_STEPS-1].sa ? -$signed({2'b0, w_yy}) : $signed({2'b0, w_yy});
            r_ax  <= r_side[SQRT_STEPS-1].sb ? -$signed({2'b0, w_xx}) : $signed({2'b0, w_xx});
            r_mst <= r_side[SQRT_STEPS-1].st;
        end
    end

    slpa_atan2 u_atan_pol (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_mvld),
        .i_y     (r_py),
        .i_x     (r_px),
        .o_valid (w_atp_vld),
        .o_ang   (w_angp)
    );

    slpa_atan2 u_atan_azi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_mvld),
        .i_y     (r_ay),
        .i_x     (r_ax),
        .o_valid (w_ata_vld),
        .o_ang   (w_anga)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ast[0] <= r_mst;
            for (int k = 1; k < ATAN_LAT; k++) begin
                r_ast[k] <= r_ast[k-1];
            end
        end
    end

    assign w_hp = 48'(w_angp) * HUND_SCALE + HUND_ROUND;
    assign w_ha = 48'(w_anga) * HUND_SCALE + HUND_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= 1'b0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_cvld <= w_atp_vld && w_ata_vld;
            r_ovld <= r_cvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hp   <= w_hp[47:32];
            r_ha   <= w_ha[47:32];
            r_cneg <= w_angp > ANG_3QUART;
            r_cst  <= r_ast[ATAN_LAT-1];

            r_ost <= r_cst;
            if (r_cst != ST_OK || r_cneg) begin
                r_opol <= '0;
            end else if (r_hp > POLAR_MAX) begin
                r_opol <= 15'(POLAR_MAX);
            end else begin
                r_opol <= 15'(r_hp);
            end
            if (r_cst != ST_OK || r_ha >= FULL_TURN) begin
                r_oazi <= '0;
            end else begin
                r_oazi <= r_ha;
            end
        end
    end

    assign o_valid         = r_ovld;
    assign o_polar_angle   = r_opol;
    assign o_azimuth_angle = r_oazi;
    assign o_status        = r_ost;

endmodule
